### sv/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the block decoder RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/bcn_pkg.sv
// ============================================================================
// Block decoder package
// Format codes, register map and divide-by-constant helpers.
// ============================================================================
package bcn_pkg;

    localparam int unsigned TexelCount = 16;
    localparam int unsigned IdxW       = $clog2(TexelCount);
    localparam logic [IdxW-1:0] LAST_TEXEL = IdxW'(TexelCount - 1);

    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;

    localparam int unsigned PaddrW = 3;
    localparam logic [PaddrW-1:0] REG_FORMAT_ADDR = 3'd0;

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'd2341;
        return p[21:14];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'd1639;
        return p[20:13];
    endfunction

endpackage

### sv/bcn_block_decoder.sv
// ============================================================================
// Block decoder top level
// Decodes one DXT1/DXT3/DXT5 4x4 block into sixteen RGBA8 texels.
// ============================================================================
// A block request is taken into an input register, then passes an endpoint
// and weighted-sum stage and a palette stage (divides by 3, 5 and 7 done as
// reciprocal multiplies), and lands in a texel serializer that emits one
// texel per cycle while the output is not stalled, in row-major order
// through an output register. The serializer holds one block for all
// sixteen of its texels; up to three further blocks queue in the stages
// ahead of it, so requests are taken while the current block is still
// streaming. The format register is written through the APB port at byte
// address 0.
module bcn_block_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bcn_pkg::PaddrW-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [63:0]                    i_color_block,
    input  logic [63:0]                    i_alpha_block,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_red,
    output logic [7:0]                     o_green,
    output logic [7:0]                     o_blue,
    output logic [7:0]                     o_alpha,
    output logic [bcn_pkg::IdxW-1:0]       o_texel_index,
    output logic                           o_last
);

    // ------------------------------------------------------------------ config
    logic [1:0] r_format;
    logic       cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[bcn_pkg::PaddrW-1:2] == bcn_pkg::REG_FORMAT_ADDR[bcn_pkg::PaddrW-1:2]);
    assign prdata  = cfg_hit ? {30'd0, r_format} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= bcn_pkg::FMT_DXT1;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_format <= pwdata[1:0];
        end
    end

    // --------------------------------------------------------------- flow ctl
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_ser_valid, r_o_valid;
    logic [bcn_pkg::IdxW-1:0] r_cnt;
    logic out_ready, ser_fire, ser_ready, s3_ready, s2_ready, s1_ready;
    logic s1_load, s2_load, s3_load, ser_load;

    assign out_ready = !r_o_valid || !i_stall;
    assign ser_fire  = r_ser_valid && out_ready;
    assign ser_ready = !r_ser_valid || (ser_fire && (r_cnt == bcn_pkg::LAST_TEXEL));
    assign s3_ready  = !r_s3_valid || ser_ready;
    assign s2_ready  = !r_s2_valid || s3_ready;
    assign s1_ready  = !r_s1_valid || s2_ready;
    assign o_stall   = !s1_ready;

    assign s1_load  = s1_ready;
    assign s2_load  = s2_ready;
    assign s3_load  = s3_ready;
    assign ser_load = r_s3_valid && ser_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_valid;
            end
            if (s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_load) begin
                r_s3_valid <= r_s2_valid;
            end
            if (out_ready) begin
                r_o_valid <= r_ser_valid;
            end
        end
    end

    // ---------------------------------------------------------- stage 1: input
    logic [63:0] r_s1_cb, r_s1_ab;
    logic [1:0]  r_s1_fmt;

    always_ff @(posedge i_clk) begin
        if (s1_load && i_valid) begin
            r_s1_cb  <= i_color_block;
            r_s1_ab  <= i_alpha_block;
            r_s1_fmt <= r_format;
        end
    end

    // ------------------------------------------------ stage 2: endpoints, sums
    logic [2:0][7:0]  n_s2_e0, n_s2_e1;
    logic [2:0][9:0]  n_s2_sum2, n_s2_sum3;
    logic [2:0][8:0]  n_s2_mid;
    logic [5:0][10:0] n_s2_as7;
    logic [3:0][10:0] n_s2_as5;
    logic             n_s2_four;
    logic [15:0]      s1_c0, s1_c1;
    logic [7:0]       s1_a0, s1_a1;

    logic [2:0][7:0]  r_s2_e0, r_s2_e1;
    logic [2:0][9:0]  r_s2_sum2, r_s2_sum3;
    logic [2:0][8:0]  r_s2_mid;
    logic [5:0][10:0] r_s2_as7;
    logic [3:0][10:0] r_s2_as5;
    logic             r_s2_four, r_s2_agt;
    logic [7:0]       r_s2_a0, r_s2_a1;
    logic [1:0]       r_s2_fmt;
    logic [31:0]      r_s2_cidx;
    logic [63:0]      r_s2_ab;

    always_comb begin
        s1_c0 = r_s1_cb[15:0];
        s1_c1 = r_s1_cb[31:16];
        s1_a0 = r_s1_ab[7:0];
        s1_a1 = r_s1_ab[15:8];
        n_s2_e0[0] = {s1_c0[15:11], s1_c0[15:13]};
        n_s2_e0[1] = {s1_c0[10:5], s1_c0[10:9]};
        n_s2_e0[2] = {s1_c0[4:0], s1_c0[4:2]};
        n_s2_e1[0] = {s1_c1[15:11], s1_c1[15:13]};
        n_s2_e1[1] = {s1_c1[10:5], s1_c1[10:9]};
        n_s2_e1[2] = {s1_c1[4:0], s1_c1[4:2]};
        for (int c = 0; c < 3; c++) begin
            n_s2_sum2[c] = {1'b0, n_s2_e0[c], 1'b0} + 10'(n_s2_e1[c]);
            n_s2_sum3[c] = 10'(n_s2_e0[c]) + {1'b0, n_s2_e1[c], 1'b0};
            n_s2_mid[c]  = 9'(n_s2_e0[c]) + 9'(n_s2_e1[c]);
        end
        for (int k = 1; k <= 6; k++) begin
            n_s2_as7[k-1] = 11'(s1_a0) * 11'(7 - k) + 11'(s1_a1) * 11'(k);
        end
        for (int k = 1; k <= 4; k++) begin
            n_s2_as5[k-1] = 11'(s1_a0) * 11'(5 - k) + 11'(s1_a1) * 11'(k);
        end
        n_s2_four = (s1_c0 > s1_c1) ||
                    ((r_s1_fmt == bcn_pkg::FMT_DXT3) || (r_s1_fmt == bcn_pkg::FMT_DXT5));
    end

    always_ff @(posedge i_clk) begin
        if (s2_load && r_s1_valid) begin
            r_s2_e0   <= n_s2_e0;
            r_s2_e1   <= n_s2_e1;
            r_s2_sum2 <= n_s2_sum2;
            r_s2_sum3 <= n_s2_sum3;
            r_s2_mid  <= n_s2_mid;
            r_s2_as7  <= n_s2_as7;
            r_s2_as5  <= n_s2_as5;
            r_s2_four <= n_s2_four;
            r_s2_agt  <= (s1_a0 > s1_a1);
            r_s2_a0   <= s1_a0;
            r_s2_a1   <= s1_a1;
            r_s2_fmt  <= r_s1_fmt;
            r_s2_cidx <= r_s1_cb[63:32];
            r_s2_ab   <= r_s1_ab;
        end
    end

    // ---------------------------------------------------------- stage 3: palette
    logic [3:0][7:0] n_s3_pr, n_s3_pg, n_s3_pb, n_s3_pa;
    logic [7:0][7:0] n_s3_al;
    logic [3:0][7:0] r_s3_pr, r_s3_pg, r_s3_pb, r_s3_pa;
    logic [7:0][7:0] r_s3_al;
    logic [1:0]      r_s3_fmt;
    logic [31:0]     r_s3_cidx;
    logic [63:0]     r_s3_ab;

    always_comb begin
        n_s3_pr[0] = r_s2_e0[0];
        n_s3_pg[0] = r_s2_e0[1];
        n_s3_pb[0] = r_s2_e0[2];
        n_s3_pr[1] = r_s2_e1[0];
        n_s3_pg[1] = r_s2_e1[1];
        n_s3_pb[1] = r_s2_e1[2];
        n_s3_pa    = {4{8'hFF}};
        if (r_s2_four) begin
            n_s3_pr[2] = bcn_pkg::div3(r_s2_sum2[0]);
            n_s3_pg[2] = bcn_pkg::div3(r_s2_sum2[1]);
            n_s3_pb[2] = bcn_pkg::div3(r_s2_sum2[2]);
            n_s3_pr[3] = bcn_pkg::div3(r_s2_sum3[0]);
            n_s3_pg[3] = bcn_pkg::div3(r_s2_sum3[1]);
            n_s3_pb[3] = bcn_pkg::div3(r_s2_sum3[2]);
        end else begin
            n_s3_pr[2] = r_s2_mid[0][8:1];
            n_s3_pg[2] = r_s2_mid[1][8:1];
            n_s3_pb[2] = r_s2_mid[2][8:1];
            n_s3_pr[3] = 8'd0;
            n_s3_pg[3] = 8'd0;
            n_s3_pb[3] = 8'd0;
            n_s3_pa[3] = 8'd0;
        end
        n_s3_al[0] = r_s2_a0;
        n_s3_al[1] = r_s2_a1;
        if (r_s2_agt) begin
            for (int k = 0; k < 6; k++) begin
                n_s3_al[k+2] = bcn_pkg::div7(r_s2_as7[k]);
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                n_s3_al[k+2] = bcn_pkg::div5(r_s2_as5[k]);
            end
            n_s3_al[6] = 8'd0;
            n_s3_al[7] = 8'hFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_load && r_s2_valid) begin
            r_s3_pr   <= n_s3_pr;
            r_s3_pg   <= n_s3_pg;
            r_s3_pb   <= n_s3_pb;
            r_s3_pa   <= n_s3_pa;
            r_s3_al   <= n_s3_al;
            r_s3_fmt  <= r_s2_fmt;
            r_s3_cidx <= r_s2_cidx;
            r_s3_ab   <= (r_s2_fmt == bcn_pkg::FMT_DXT5) ? (r_s2_ab >> 16) : r_s2_ab;
        end
    end

    // ------------------------------------------------------ texel serializer
    logic [3:0][7:0] r_ser_pr, r_ser_pg, r_ser_pb, r_ser_pa;
    logic [7:0][7:0] r_ser_al;
    logic [1:0]      r_ser_fmt;
    logic [31:0]     r_ser_cidx;
    logic [63:0]     r_ser_ab;
    logic [1:0]      ci;
    logic [7:0]      n_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_cnt       <= '0;
        end else if (ser_load) begin
            r_ser_valid <= 1'b1;
            r_cnt       <= '0;
        end else if (ser_fire) begin
            if (r_cnt == bcn_pkg::LAST_TEXEL) begin
                r_ser_valid <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_ser_pr   <= r_s3_pr;
            r_ser_pg   <= r_s3_pg;
            r_ser_pb   <= r_s3_pb;
            r_ser_pa   <= r_s3_pa;
            r_ser_al   <= r_s3_al;
            r_ser_fmt  <= r_s3_fmt;
            r_ser_cidx <= r_s3_cidx;
            r_ser_ab   <= r_s3_ab;
        end else if (ser_fire) begin
            r_ser_cidx <= r_ser_cidx >> 2;
            r_ser_ab   <= (r_ser_fmt == bcn_pkg::FMT_DXT5) ? (r_ser_ab >> 3) : (r_ser_ab >> 4);
        end
    end

    assign ci = r_ser_cidx[1:0];

    always_comb begin
        unique case (r_ser_fmt)
            bcn_pkg::FMT_DXT3: n_alpha = {r_ser_ab[3:0], r_ser_ab[3:0]};
            bcn_pkg::FMT_DXT5: n_alpha = r_ser_al[r_ser_ab[2:0]];
            default:           n_alpha = r_ser_pa[ci];
        endcase
    end

    // ----------------------------------------------------------- output stage
    logic [7:0]               r_o_red, r_o_green, r_o_blue, r_o_alpha;
    logic [bcn_pkg::IdxW-1:0] r_o_idx;
    logic                     r_o_last;

    always_ff @(posedge i_clk) begin
        if (ser_fire) begin
            r_o_red   <= r_ser_pr[ci];
            r_o_green <= r_ser_pg[ci];
            r_o_blue  <= r_ser_pb[ci];
            r_o_alpha <= n_alpha;
            r_o_idx   <= r_cnt;
            r_o_last  <= (r_cnt == bcn_pkg::LAST_TEXEL);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_red         = r_o_red;
    assign o_green       = r_o_green;
    assign o_blue        = r_o_blue;
    assign o_alpha       = r_o_alpha;
    assign o_texel_index = r_o_idx;
    assign o_last        = r_o_last;

    // ------------------------------------------------------------- assertions
`include "assert_macros.svh"

    `ASSERT_IMPL(a_last_on_final, i_clk, i_rst_n, o_valid, o_last == (o_texel_index == bcn_pkg::LAST_TEXEL))
    `ASSERT_IMPL(a_idle_count, i_clk, i_rst_n, !r_ser_valid, r_cnt == '0)
    `ASSERT_NEXT(a_texel_order, i_clk, i_rst_n, o_valid && !i_stall && !o_last, o_valid && (o_texel_index == $past(o_texel_index) + 1'b1))

endmodule
